@@ rtl/sbt_pkg.sv @@
// Shared constants and transaction types for the swept box time of impact core.
package sbt_pkg;

    localparam int TIME_FRAC_BITS = 16;
    localparam int TIME_W  = TIME_FRAC_BITS + 3;
    localparam int OUT_T_W = TIME_FRAC_BITS + 1;
    localparam int NSTEP   = TIME_FRAC_BITS + 2;
    localparam int DIV_STG = NSTEP + 1;
    localparam int NSTG    = NSTEP + 4;
    localparam int MAG_W   = 18;
    localparam int DEN_W   = 17;
    localparam int REM_W   = 19;

    localparam logic signed [TIME_W-1:0] T_ONE = TIME_W'(1) <<< TIME_FRAC_BITS;
    localparam logic signed [TIME_W-1:0] T_SAT = TIME_W'(1) <<< (TIME_FRAC_BITS + 1);

    typedef struct packed {
        logic signed [15:0] mover_x;
        logic signed [15:0] mover_y;
        logic [14:0]        mover_w;
        logic [14:0]        mover_h;
        logic signed [15:0] mover_vx;
        logic signed [15:0] mover_vy;
        logic signed [15:0] surface_x;
        logic signed [15:0] surface_y;
        logic [14:0]        surface_w;
        logic [14:0]        surface_h;
        logic signed [15:0] surface_vx;
        logic signed [15:0] surface_vy;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic [OUT_T_W-1:0] impact_time;
        logic               normal_axis;
    } t_out;

    typedef struct packed {
        logic zx;
        logic zy;
        logic ovx;
        logic ovy;
    } t_flags;

endpackage

@@ rtl/sbt_div.sv @@
// Pipelined restoring divider giving a floored, saturated time quotient.
module sbt_div
    import sbt_pkg::*;
(
    input  logic                     i_clk,
    input  logic [DIV_STG-1:0]       i_en,
    input  logic [MAG_W-1:0]         i_a,
    input  logic [DEN_W-1:0]         i_b,
    input  logic                     i_neg,
    output logic signed [TIME_W-1:0] o_q
);

    logic [REM_W-1:0] r_rem [NSTEP];
    logic [NSTEP-1:0] r_q   [NSTEP];
    logic [DEN_W-1:0] r_b   [NSTEP];
    logic             r_neg [NSTEP];
    logic             r_sat [NSTEP];
    logic signed [TIME_W-1:0] r_res;

    genvar j;
    generate
        for (j = 0; j < NSTEP; j++) begin : g_step
            logic [REM_W-1:0] w_t;
            logic [REM_W-1:0] w_d;
            logic             w_ge;
            logic [NSTEP-1:0] w_qp;
            if (j == 0) begin : g_first
                assign w_t  = REM_W'(i_a);
                assign w_d  = REM_W'({i_b, 1'b0});
                assign w_qp = '0;
                always_ff @(posedge i_clk) begin
                    if (i_en[j]) begin
                        r_b[j]   <= i_b;
                        r_neg[j] <= i_neg;
                        r_sat[j] <= (REM_W'(i_a) >= REM_W'({i_b, 2'b00}));
                    end
                end
            end else if (j == 1) begin : g_second
                assign w_t  = r_rem[j-1];
                assign w_d  = REM_W'(r_b[j-1]);
                assign w_qp = r_q[j-1];
                always_ff @(posedge i_clk) begin
                    if (i_en[j]) begin
                        r_b[j]   <= r_b[j-1];
                        r_neg[j] <= r_neg[j-1];
                        r_sat[j] <= r_sat[j-1];
                    end
                end
            end else begin : g_frac
                assign w_t  = {r_rem[j-1][REM_W-2:0], 1'b0};
                assign w_d  = REM_W'(r_b[j-1]);
                assign w_qp = r_q[j-1];
                always_ff @(posedge i_clk) begin
                    if (i_en[j]) begin
                        r_b[j]   <= r_b[j-1];
                        r_neg[j] <= r_neg[j-1];
                        r_sat[j] <= r_sat[j-1];
                    end
                end
            end
            assign w_ge = (w_t >= w_d);
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= w_ge ? (w_t - w_d) : w_t;
                    r_q[j]   <= {w_qp[NSTEP-2:0], w_ge};
                end
            end
        end
    endgenerate

    logic signed [TIME_W-1:0] w_mag;
    logic signed [TIME_W-1:0] w_up;
    logic signed [TIME_W-1:0] n_res;

    always_comb begin
        w_mag = $signed(TIME_W'(r_q[NSTEP-1]));
        w_up  = w_mag + $signed(TIME_W'(r_rem[NSTEP-1] != '0));
        if (!r_neg[NSTEP-1]) begin
            n_res = (r_sat[NSTEP-1] || w_mag > T_SAT) ? T_SAT : w_mag;
        end else begin
            n_res = (r_sat[NSTEP-1] || w_up > T_SAT) ? -T_SAT : -w_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[NSTEP]) begin
            r_res <= n_res;
        end
    end

    assign o_q = r_res;

endmodule

@@ rtl/swept_box_time_of_impact_core.sv @@
// Top level of the swept box time of impact core.
// Usage:
//   Input channel i_valid/o_ready carries one box pair per transaction in i_item;
//   output channel o_valid/i_ready returns one result per pair in o_item, in order.
//   Each pair gives hit, impact_time (unsigned, TIME_FRAC_BITS fraction bits,
//   1.0 when no hit) and normal_axis.
// Throughput: one transaction per cycle when the receiver keeps i_ready high.
// Datapath: the divider resolves one quotient bit per stage, four lanes side by side
//   (entry and exit times on both axes).
// Stalls: each stage holds its transaction while the stage after it is full and
//   stalled; empty stages keep filling, so bubbles close up behind a stall and the
//   core still takes input until every stage holds a transaction.
// Reset: i_rst_n low at a clock edge empties every stage; o_valid drops and
//   o_ready is high on the next cycle.
module swept_box_time_of_impact_core
    import sbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_item
);

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   w_en;

    assign w_en[NSTG] = i_ready;
    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_en
            assign w_en[k] = !r_v[k] || w_en[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    t_in r_in;
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_in <= i_item;
        end
    end

    logic signed [16:0] w_vx, w_vy;
    logic signed [16:0] w_cmx, w_smx, w_cmy, w_smy;
    logic signed [17:0] w_dinx, w_doutx, w_diny, w_douty;
    logic [MAG_W-1:0]   n_ainx, n_aoutx, n_ainy, n_aouty;
    logic [DEN_W-1:0]   n_bx, n_by;
    logic               n_ninx, n_noutx, n_niny, n_nouty;
    t_flags             n_fl;

    always_comb begin
        w_vx  = 17'(r_in.mover_vx) - 17'(r_in.surface_vx);
        w_vy  = 17'(r_in.mover_vy) - 17'(r_in.surface_vy);
        w_cmx = 17'(r_in.mover_x) + $signed({2'b00, r_in.mover_w});
        w_smx = 17'(r_in.surface_x) + $signed({2'b00, r_in.surface_w});
        w_cmy = 17'(r_in.mover_y) + $signed({2'b00, r_in.mover_h});
        w_smy = 17'(r_in.surface_y) + $signed({2'b00, r_in.surface_h});
        if (w_vx > 0) begin
            w_dinx  = 18'(r_in.surface_x) - 18'(w_cmx);
            w_doutx = 18'(w_smx) - 18'(r_in.mover_x);
        end else begin
            w_dinx  = 18'(w_smx) - 18'(r_in.mover_x);
            w_doutx = 18'(r_in.surface_x) - 18'(w_cmx);
        end
        if (w_vy > 0) begin
            w_diny  = 18'(r_in.surface_y) - 18'(w_cmy);
            w_douty = 18'(w_smy) - 18'(r_in.mover_y);
        end else begin
            w_diny  = 18'(w_smy) - 18'(r_in.mover_y);
            w_douty = 18'(r_in.surface_y) - 18'(w_cmy);
        end
        n_ainx  = w_dinx[17]  ? MAG_W'(-w_dinx)  : MAG_W'(w_dinx);
        n_aoutx = w_doutx[17] ? MAG_W'(-w_doutx) : MAG_W'(w_doutx);
        n_ainy  = w_diny[17]  ? MAG_W'(-w_diny)  : MAG_W'(w_diny);
        n_aouty = w_douty[17] ? MAG_W'(-w_douty) : MAG_W'(w_douty);
        n_bx    = w_vx[16] ? DEN_W'(-w_vx) : DEN_W'(w_vx);
        n_by    = w_vy[16] ? DEN_W'(-w_vy) : DEN_W'(w_vy);
        n_ninx  = w_dinx[17]  ^ w_vx[16];
        n_noutx = w_doutx[17] ^ w_vx[16];
        n_niny  = w_diny[17]  ^ w_vy[16];
        n_nouty = w_douty[17] ^ w_vy[16];
        n_fl.zx  = (w_vx == '0);
        n_fl.zy  = (w_vy == '0);
        n_fl.ovx = !(w_cmx < 17'(r_in.surface_x) || 17'(r_in.mover_x) > w_smx);
        n_fl.ovy = !(w_cmy < 17'(r_in.surface_y) || 17'(r_in.mover_y) > w_smy);
    end

    logic [MAG_W-1:0] r_ainx, r_aoutx, r_ainy, r_aouty;
    logic [DEN_W-1:0] r_bx, r_by;
    logic             r_ninx, r_noutx, r_niny, r_nouty;
    t_flags           r_fl [1:NSTEP+2];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_ainx  <= n_ainx;
            r_aoutx <= n_aoutx;
            r_ainy  <= n_ainy;
            r_aouty <= n_aouty;
            r_bx    <= n_bx;
            r_by    <= n_by;
            r_ninx  <= n_ninx;
            r_noutx <= n_noutx;
            r_niny  <= n_niny;
            r_nouty <= n_nouty;
            r_fl[1] <= n_fl;
        end
    end

    generate
        for (k = 2; k <= NSTEP + 2; k++) begin : g_fl
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_fl[k] <= r_fl[k-1];
                end
            end
        end
    endgenerate

    logic signed [TIME_W-1:0] w_qinx, w_qoutx, w_qiny, w_qouty;

    sbt_div u_div_inx (
        .i_clk(i_clk), .i_en(w_en[NSTEP+2:2]), .i_a(r_ainx), .i_b(r_bx),
        .i_neg(r_ninx), .o_q(w_qinx)
    );
    sbt_div u_div_outx (
        .i_clk(i_clk), .i_en(w_en[NSTEP+2:2]), .i_a(r_aoutx), .i_b(r_bx),
        .i_neg(r_noutx), .o_q(w_qoutx)
    );
    sbt_div u_div_iny (
        .i_clk(i_clk), .i_en(w_en[NSTEP+2:2]), .i_a(r_ainy), .i_b(r_by),
        .i_neg(r_niny), .o_q(w_qiny)
    );
    sbt_div u_div_outy (
        .i_clk(i_clk), .i_en(w_en[NSTEP+2:2]), .i_a(r_aouty), .i_b(r_by),
        .i_neg(r_nouty), .o_q(w_qouty)
    );

    t_flags                   w_f;
    logic signed [TIME_W-1:0] w_ex, w_xx, w_ey, w_xy, w_late, w_early;
    logic                     w_ok;
    t_out                     n_out;
    t_out                     r_out;

    always_comb begin
        w_f     = r_fl[NSTEP+2];
        w_ex    = w_f.zx ? -T_SAT : w_qinx;
        w_xx    = w_f.zx ?  T_SAT : w_qoutx;
        w_ey    = w_f.zy ? -T_SAT : w_qiny;
        w_xy    = w_f.zy ?  T_SAT : w_qouty;
        w_late  = (w_ex > w_ey) ? w_ex : w_ey;
        w_early = (w_xx < w_xy) ? w_xx : w_xy;
        w_ok    = (!w_f.zx || w_f.ovx) && (!w_f.zy || w_f.ovy);
        if (w_late > w_early) w_ok = 1'b0;
        if (w_ex < 0 && w_ey < 0) w_ok = 1'b0;
        if (w_ex > T_ONE || w_ey > T_ONE) w_ok = 1'b0;
        if (w_ex < 0 && !w_f.ovx) w_ok = 1'b0;
        if (w_ey < 0 && !w_f.ovy) w_ok = 1'b0;
        if (w_late >= T_ONE) w_ok = 1'b0;
        if (w_ok) begin
            n_out.hit         = 1'b1;
            n_out.impact_time = w_late[OUT_T_W-1:0];
            n_out.normal_axis = !(w_ex > w_ey);
        end else begin
            n_out.hit         = 1'b0;
            n_out.impact_time = T_ONE[OUT_T_W-1:0];
            n_out.normal_axis = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            r_out <= n_out;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_item  = r_out;

endmodule

@@ rtl/sbt_checker.sv @@
// Port-level checker for the swept box time of impact core, with its bind.
module sbt_checker
    import sbt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input t_out o_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("output transaction changed while stalled");

    a_hit_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.hit |-> o_item.impact_time < T_ONE[OUT_T_W-1:0])
        else $error("hit with impact time not below one");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.hit |->
            o_item.impact_time == T_ONE[OUT_T_W-1:0] && !o_item.normal_axis)
        else $error("miss with wrong time or axis");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind swept_box_time_of_impact_core sbt_checker u_sbt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_item(o_item)
);

@@ tb/testbench.sv @@
// Testbench for the swept box time of impact core: directed table plus random pairs, checked against a predictor.
module testbench
    import sbt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 1750;
    localparam longint ONE_Q = 64'sd1 <<< TIME_FRAC_BITS;
    localparam longint SAT_Q = 2 * ONE_Q;

    typedef struct {
        t_in  pair;
        logic has_answer;
        t_out answer;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_item;
    logic o_valid;
    logic i_ready;
    t_out o_item;

    t_out   impact_q[$];
    int     mismatches;
    t_row   directed[$];

    swept_box_time_of_impact_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint quotient_time(longint num, longint den);
        longint n;
        longint q;
        n = num * ONE_Q;
        if (den < 0) begin
            n = -n;
            den = -den;
        end
        q = n / den;
        if ((n % den) != 0 && n < 0) q = q - 1;
        if (q > SAT_Q) q = SAT_Q;
        if (q < -SAT_Q) q = -SAT_Q;
        return q;
    endfunction

    function automatic bit spans_meet(longint lo_a, longint hi_a, longint lo_b, longint hi_b);
        return !(hi_a < lo_b || lo_a > hi_b);
    endfunction

    function automatic bit axis_span(longint c, longint cs, longint s, longint ss, longint v,
                                     output longint t_in_, output longint t_out_);
        if (v == 0) begin
            t_in_ = -SAT_Q;
            t_out_ = SAT_Q;
            return spans_meet(c, c + cs, s, s + ss);
        end
        if (v > 0) begin
            t_in_ = quotient_time(s - (c + cs), v);
            t_out_ = quotient_time((s + ss) - c, v);
        end else begin
            t_in_ = quotient_time((s + ss) - c, v);
            t_out_ = quotient_time(s - (c + cs), v);
        end
        return 1'b1;
    endfunction

    function automatic t_out predict_impact(t_in p);
        longint ex, xx, ey, xy, latest, earliest;
        longint mx, my, sx, sy, mw, mh, sw, sh;
        bit ok;
        t_out r;
        mx = p.mover_x; my = p.mover_y; sx = p.surface_x; sy = p.surface_y;
        mw = p.mover_w; mh = p.mover_h; sw = p.surface_w; sh = p.surface_h;
        ok = axis_span(mx, mw, sx, sw, longint'(p.mover_vx) - longint'(p.surface_vx), ex, xx);
        ok = axis_span(my, mh, sy, sh, longint'(p.mover_vy) - longint'(p.surface_vy), ey, xy)
             && ok;
        latest = (ex > ey) ? ex : ey;
        earliest = (xx < xy) ? xx : xy;
        if (ok && latest > earliest) ok = 0;
        if (ok && ex < 0 && ey < 0) ok = 0;
        if (ok && (ex > ONE_Q || ey > ONE_Q)) ok = 0;
        if (ok && ex < 0 && !spans_meet(mx, mx + mw, sx, sx + sw)) ok = 0;
        if (ok && ey < 0 && !spans_meet(my, my + mh, sy, sy + sh)) ok = 0;
        if (ok && latest >= ONE_Q) ok = 0;
        if (ok) begin
            r.hit = 1'b1;
            r.impact_time = latest[OUT_T_W-1:0];
            r.normal_axis = (ex > ey) ? 1'b0 : 1'b1;
        end else begin
            r.hit = 1'b0;
            r.impact_time = ONE_Q[OUT_T_W-1:0];
            r.normal_axis = 1'b0;
        end
        return r;
    endfunction

    function automatic t_in make_pair(int mx, int my, int mw, int mh, int mvx, int mvy,
                                      int sx, int sy, int sw, int sh, int svx, int svy);
        t_in p;
        p.mover_x = 16'(mx); p.mover_y = 16'(my); p.mover_w = 15'(mw); p.mover_h = 15'(mh);
        p.mover_vx = 16'(mvx); p.mover_vy = 16'(mvy);
        p.surface_x = 16'(sx); p.surface_y = 16'(sy); p.surface_w = 15'(sw);
        p.surface_h = 15'(sh); p.surface_vx = 16'(svx); p.surface_vy = 16'(svy);
        return p;
    endfunction

    function automatic t_row row(t_in p, logic known, logic h, int t, logic ax);
        t_row r;
        r.pair = p;
        r.has_answer = known;
        r.answer.hit = h;
        r.answer.impact_time = OUT_T_W'(t);
        r.answer.normal_axis = ax;
        return r;
    endfunction

    function automatic void add_row(t_row r);
        directed.insert(directed.size(), r);
    endfunction

    function automatic t_in random_pair();
        t_in p;
        int span;
        logic [191:0] raw;
        if ($urandom_range(0, 9) < 7) begin
            span = (1 << $urandom_range(3, 15)) - 1;
            p.mover_x = 16'($urandom_range(0, 2 * span) - span);
            p.mover_y = 16'($urandom_range(0, 2 * span) - span);
            p.surface_x = 16'($urandom_range(0, 2 * span) - span);
            p.surface_y = 16'($urandom_range(0, 2 * span) - span);
            p.mover_w = 15'($urandom_range(0, span / 2));
            p.mover_h = 15'($urandom_range(0, span / 2));
            p.surface_w = 15'($urandom_range(0, span / 2));
            p.surface_h = 15'($urandom_range(0, span / 2));
            p.mover_vx = 16'($urandom_range(0, 4 * span) - 2 * span);
            p.mover_vy = 16'($urandom_range(0, 4 * span) - 2 * span);
            p.surface_vx = ($urandom_range(0, 3) == 0) ? p.mover_vx
                                                        : 16'($urandom_range(0, 2 * span) - span);
            p.surface_vy = ($urandom_range(0, 3) == 0) ? p.mover_vy
                                                        : 16'($urandom_range(0, 2 * span) - span);
        end else begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            p = raw[$bits(t_in)-1:0];
        end
        return p;
    endfunction

    task automatic send_pair(t_in p);
        i_item <= p;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        impact_q.insert(impact_q.size(), predict_impact(p));
        @(negedge i_clk);
    endtask

    task automatic maybe_gap(ref int burst);
        int gap;
        if (burst > 0) begin
            burst--;
            return;
        end
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else case ($time / 2000 % 4)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= ($urandom_range(0, 1) != 0);
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (impact_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_item);
            end else begin
                want = impact_q.pop_front();
                if (o_item.hit !== want.hit || o_item.impact_time !== want.impact_time
                    || o_item.normal_axis !== want.normal_axis) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, o_item);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        int burst;
        t_out got_known;
        mismatches = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        burst = 0;
        // Rows (known answer where marked): still boxes apart, all-zero overlap, approach to touching, extremes.
        add_row(row(make_pair(0, 0, 10, 10, 0, 0, 100, 100, 10, 10, 0, 0),
                    1, 0, 65536, 0));
        add_row(row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        add_row(row(make_pair(0, 0, 10, 10, 20, 0, 20, 0, 10, 10, 0, 0),
                    1, 1, 32768, 0));
        add_row(row(make_pair(0, 0, 10, 10, 0, 20, 0, 20, 10, 10, 0, 0), 0, 0, 0, 0));
        add_row(row(make_pair(-32768, -32768, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767, 32767, -32768, -32768), 0, 0, 0, 0));
        add_row(row(make_pair(32767, 32767, 32767, 32767, -32768, -32768,
                              -32768, -32768, 32767, 32767, 32767, 32767), 0, 0, 0, 0));
        add_row(row(make_pair(-32768, 0, 0, 0, -32768, 0, 32767, 0, 0, 0, 32767, 0),
                    0, 0, 0, 0));
        add_row(row(make_pair(0, 0, 10, 10, 5, 5, 20, 15, 10, 10, 0, 0), 0, 0, 0, 0));
        add_row(row(make_pair(0, 0, 10, 10, -30, -30, -25, -20, 5, 5, 0, 0),
                    0, 0, 0, 0));
        add_row(row(make_pair(0, 0, 10, 10, 3, 0, 100, 0, 10, 10, 0, 0),
                    1, 0, 65536, 0));
        add_row(row(make_pair(0, 0, 10, 10, 40, 2, 20, 50, 10, 10, 0, 0),
                    1, 0, 65536, 0));
        add_row(row(make_pair(0, 0, 10, 10, 10, 10, -50, 5, 10, 10, 0, 0),
                    1, 0, 65536, 0));
        add_row(row(make_pair(0, 0, 10, 10, 5, 5, 0, 0, 10, 10, 0, 0), 0, 0, 0, 0));
        add_row(row(make_pair(0, 0, 10, 10, 0, 7, 50, 0, 10, 10, 0, 0),
                    1, 0, 65536, 0));
        add_row(row(make_pair(0, 0, 10, 10, 10, 10, 20, 20, 10, 10, 0, 0), 0, 0, 0, 0));
        add_row(row(make_pair(0, 0, 10, 10, 7, 3, 15, 0, 10, 10, -7, 1), 0, 0, 0, 0));
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[k]) begin
            if (directed[k].has_answer) begin
                got_known = predict_impact(directed[k].pair);
                if (got_known !== directed[k].answer) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: expected %p, predictor %p",
                                 k, directed[k].answer, got_known);
                end
            end
            send_pair(directed[k].pair);
            maybe_gap(burst);
        end
        for (int n = 0; n < NUM_RANDOM; n++) begin
            send_pair(random_pair());
            maybe_gap(burst);
        end
        i_valid <= 1'b0;
        while (impact_q.size() != 0) @(posedge i_clk);
        repeat (TIME_FRAC_BITS + 20) @(posedge i_clk);
        if (mismatches == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

endmodule
